// ----- rtl/core/mbse_pkg.sv -----
// Package for the monochrome sprite expander: screen constants, register
// indexes, configuration and queue entry types. No dependencies.
package mbse_pkg;

  // Screen and sprite geometry
  localparam int SCREEN_WIDTH    = 320;
  localparam int SCREEN_HEIGHT   = 200;
  localparam int MAX_SPRITE_SIZE = 256;

  // Depth of the queue between classifier and write sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR      = 3'd4;

  typedef struct packed {
    logic signed [11:0] sprite_x;
    logic signed [11:0] sprite_y;
    logic [8:0]         sprite_width;
    logic [8:0]         sprite_height;
    logic [7:0]         fg_color;
  } cfg_t;

  // One classified byte: visible pixel mask, offset of bit 0, color
  typedef struct packed {
    logic [7:0]  mask;
    logic [15:0] base;
    logic [7:0]  color;
  } entry_t;

endpackage

// ----- rtl/core/mbse_front.sv -----
// Front end: tracks sprite row and byte column, classifies each accepted
// byte into a mask of on-screen pixels and a base offset. Uses mbse_pkg.
module mbse_front (
  input  logic                clk,
  input  logic                rst,
  input  mbse_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic [7:0]          bitmap_byte,
  input  logic                first_byte,
  output logic                entry_valid,
  output mbse_pkg::entry_t    entry
);

  logic [4:0] byte_column;
  logic [7:0] sprite_row;
  logic [4:0] byte_column_next;
  logic [7:0] sprite_row_next;

  logic [4:0]         col_e;
  logic [7:0]         row_e;
  logic [8:0]         width;
  logic [5:0]         row_bytes;
  logic               row_ok;
  logic               col_ok;
  logic signed [13:0] px0;
  logic signed [13:0] py;
  logic               py_ok;
  logic [31:0]        row_prod;
  logic [7:0]         mask;

  // Restart position on a first byte
  always_comb begin
    col_e = first_byte ? 5'd0 : byte_column;
    row_e = first_byte ? 8'd0 : sprite_row;
  end

  // Clamp width and derive bytes per row
  always_comb begin
    if (cfg.sprite_width > 9'(mbse_pkg::MAX_SPRITE_SIZE)) begin
      width = 9'(mbse_pkg::MAX_SPRITE_SIZE);
    end else begin
      width = cfg.sprite_width;
    end
    row_bytes = 6'((10'(width) + 10'd7) >> 3);
  end

  // Screen position of this byte's row and first pixel
  always_comb begin
    row_ok   = 9'(row_e) < cfg.sprite_height;
    col_ok   = 6'(col_e) < row_bytes;
    px0      = 14'(cfg.sprite_x) + $signed({6'd0, col_e, 3'd0});
    py       = 14'(cfg.sprite_y) + $signed({6'd0, row_e});
    py_ok    = !py[13] && (py[12:0] < 13'(mbse_pkg::SCREEN_HEIGHT));
    row_prod = 32'(py[12:0]) * 32'(mbse_pkg::SCREEN_WIDTH);
  end

  // Keep set bits that are inside the sprite and on screen
  always_comb begin
    logic [7:0]         sx_pix;
    logic signed [13:0] px;
    for (int b = 0; b < 8; b++) begin
      sx_pix  = {col_e, 3'(b)};
      px      = px0 + 14'(b);
      mask[b] = bitmap_byte[b] && (9'(sx_pix) < width) &&
                !px[13] && (px[12:0] < 13'(mbse_pkg::SCREEN_WIDTH)) &&
                row_ok && col_ok && py_ok;
    end
  end

  // Hand bytes with visible pixels to the queue
  always_comb begin
    entry_valid = accept && (mask != 8'd0);
    entry.mask  = mask;
    entry.base  = row_prod[15:0] + {{2{px0[13]}}, px0};
    entry.color = cfg.fg_color;
  end

  // Advance column, then row, after every byte
  always_comb begin
    byte_column_next = byte_column;
    sprite_row_next  = sprite_row;
    if (accept) begin
      if (7'(col_e) + 7'd1 >= 7'(row_bytes)) begin
        byte_column_next = 5'd0;
        if (9'(row_e) + 9'd1 == cfg.sprite_height) begin
          sprite_row_next = 8'd0;
        end else begin
          sprite_row_next = row_e + 8'd1;
        end
      end else begin
        byte_column_next = col_e + 5'd1;
        sprite_row_next  = row_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= 5'd0;
      sprite_row  <= 8'd0;
    end else begin
      byte_column <= byte_column_next;
      sprite_row  <= sprite_row_next;
    end
  end

endmodule

// ----- rtl/core/mbse_queue.sv -----
// Short register queue of classified bytes between front and back ends.
// Uses mbse_pkg for depth and entry type.
module mbse_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  mbse_pkg::entry_t wr_data,
  input  logic             rd_en,
  output mbse_pkg::entry_t rd_data,
  output logic             q_full,
  output logic             q_empty
);

  mbse_pkg::entry_t slots [mbse_pkg::QUEUE_DEPTH];
  logic [mbse_pkg::QPTR_W-1:0] head;
  logic [mbse_pkg::QPTR_W-1:0] tail;
  logic [mbse_pkg::QCNT_W-1:0] count;

  assign q_full  = count == mbse_pkg::QCNT_W'(mbse_pkg::QUEUE_DEPTH);
  assign q_empty = count == '0;
  assign rd_data = slots[head];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[tail] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        tail <= tail + 1'b1;
      end
      if (rd_en) begin
        head <= head + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/mbse_back.sv -----
// Back end: walks the pixel mask of one queued byte, one framebuffer write per
// cycle unless stalled, into a registered result stage. Uses mbse_pkg entry type.
module mbse_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  mbse_pkg::entry_t q_head,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [15:0]      pixel_offset,
  output logic [7:0]       pixel_color,
  output logic             last_of_byte
);

  logic        w_valid;
  logic [7:0]  w_mask;
  logic [15:0] w_base;
  logic [7:0]  w_color;
  logic        o_valid;

  logic        emit;
  logic [2:0]  idx;
  logic [7:0]  rest;
  logic        w_done;

  // Pick the leftmost remaining pixel
  always_comb begin
    idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (w_mask[b]) begin
        idx = 3'(b);
      end
    end
    rest   = w_mask & ~(8'd1 << idx);
    emit   = w_valid && (!o_valid || pop);
    w_done = !w_valid || (emit && (rest == 8'd0));
    q_pop  = w_done && !q_empty;
  end

  assign empty = !o_valid;

  // Load the next byte or drop the pixel just written
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (q_pop) begin
      w_valid <= 1'b1;
    end else if (emit) begin
      w_valid <= rest != 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_mask  <= q_head.mask;
      w_base  <= q_head.base;
      w_color <= q_head.color;
    end else if (emit) begin
      w_mask <= rest;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (pop) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_offset <= w_base + 16'(idx);
      pixel_color  <= w_color;
      last_of_byte <= rest == 8'd0;
    end
  end

endmodule

// ----- rtl/core/mono_bitmap_sprite_expander_top.sv -----
// Top level of the monochrome sprite expander: configuration registers,
// front end, queue and back end. Uses mbse_pkg, mbse_front, mbse_queue, mbse_back.
//
//   channel   handshake              payload
//   input     push / full            bitmap_byte, first_byte
//   result    empty / pop            pixel_offset, pixel_color, last_of_byte
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte is taken every cycle while the four-entry queue has room; bytes
// with no visible pixel leave nothing in the queue.
// The back end writes one pixel per cycle unless its result stage stalls, one
// write per visible pixel of a byte (up to 8); that sequencer sets the sustained rate.
// Reset clears counters, queue and result stage; no clearing pass.
// A stalled result stage holds its write and lets the queue fill behind it.
module mono_bitmap_sprite_expander_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       bitmap_byte,
  input  logic                             first_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [15:0]                      pixel_offset,
  output logic [7:0]                       pixel_color,
  output logic                             last_of_byte,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbse_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mbse_pkg::cfg_t   cfg;
  mbse_pkg::entry_t fe_entry;
  mbse_pkg::entry_t q_head;
  logic             fe_valid;
  logic             accept;
  logic             q_pop;
  logic             q_empty;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_x      <= 12'sd0;
      cfg.sprite_y      <= 12'sd0;
      cfg.sprite_width  <= 9'd8;
      cfg.sprite_height <= 9'd8;
      cfg.fg_color      <= 8'd15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbse_pkg::REG_SPRITE_X:      cfg.sprite_x      <= $signed(cfg_data);
        mbse_pkg::REG_SPRITE_Y:      cfg.sprite_y      <= $signed(cfg_data);
        mbse_pkg::REG_SPRITE_WIDTH:  cfg.sprite_width  <= cfg_data[8:0];
        mbse_pkg::REG_SPRITE_HEIGHT: cfg.sprite_height <= cfg_data[8:0];
        mbse_pkg::REG_FG_COLOR:      cfg.fg_color      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mbse_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .bitmap_byte (bitmap_byte),
    .first_byte  (first_byte),
    .entry_valid (fe_valid),
    .entry       (fe_entry)
  );

  mbse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fe_valid),
    .wr_data (fe_entry),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_full  (full),
    .q_empty (q_empty)
  );

  mbse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .pixel_offset (pixel_offset),
    .pixel_color  (pixel_color),
    .last_of_byte (last_of_byte)
  );

endmodule

// ----- dv/tb.sv -----
// Testbench for mono_bitmap_sprite_expander_top: drives bitmap byte requests and register
// writes, predicts every framebuffer write, and checks the result queue. Uses mbse_pkg.
`timescale 1ns / 100ps

module tb;
  import mbse_pkg::*;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS   = 40;
  // First register index that the block does not decode
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 3'd5;

  typedef struct {
    logic [7:0] bits;
    logic       restart;
  } sprite_byte_t;

  typedef struct {
    logic [15:0] offset;
    logic [7:0]  color;
    logic        tail;
  } pixel_write_t;

  logic                   clk;
  logic                   rst         = 1'b1;
  logic                   push        = 1'b0;
  logic                   full;
  logic [7:0]             bitmap_byte = 8'd0;
  logic                   first_byte  = 1'b0;
  logic                   empty;
  logic                   pop         = 1'b0;
  logic [15:0]            pixel_offset;
  logic [7:0]             pixel_color;
  logic                   last_of_byte;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  sprite_byte_t bytes_to_send[$];
  pixel_write_t pending_writes[$];
  pixel_write_t want_write;

  // Predicted register file and sprite walk position
  cfg_t       sprite_cfg;
  logic [4:0] cur_col;
  logic [7:0] cur_row;

  int  send_gap, recv_gap;
  int  send_odds = 0, recv_odds = 0;
  bit  calm = 1'b0;
  int  mismatches = 0;
  int  bytes_accepted = 0, writes_seen = 0, settings = 0;
  int  queued_items = 0;
  int  cycles = 0;

  mono_bitmap_sprite_expander_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .bitmap_byte  (bitmap_byte),
    .first_byte   (first_byte),
    .empty        (empty),
    .pop          (pop),
    .pixel_offset (pixel_offset),
    .pixel_color  (pixel_color),
    .last_of_byte (last_of_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Expand one accepted byte into its visible pixel writes, then advance the walk
  function automatic void expand_byte(input logic [7:0] bits, input logic restart);
    int width, row_bytes, sx, px, py, n;
    pixel_write_t w;
    width     = (sprite_cfg.sprite_width > MAX_SPRITE_SIZE) ? MAX_SPRITE_SIZE
                                                            : int'(sprite_cfg.sprite_width);
    row_bytes = (width + 7) / 8;
    n         = 0;
    if (restart) begin
      cur_col = '0;
      cur_row = '0;
    end
    py = int'(sprite_cfg.sprite_y) + int'(cur_row);
    if (cur_row < sprite_cfg.sprite_height && int'(cur_col) < row_bytes) begin
      for (int b = 0; b < 8; b++) begin
        sx = int'(cur_col) * 8 + b;
        px = int'(sprite_cfg.sprite_x) + sx;
        if (sx < width && bits[b] && px >= 0 && px < SCREEN_WIDTH &&
            py >= 0 && py < SCREEN_HEIGHT) begin
          w.offset = 16'(py * SCREEN_WIDTH + px);
          w.color  = sprite_cfg.fg_color;
          w.tail   = 1'b0;
          pending_writes.push_back(w);
          n++;
        end
      end
      if (n > 0) pending_writes[pending_writes.size() - 1].tail = 1'b1;
    end
    if (int'(cur_col) + 1 >= row_bytes) begin
      cur_col = '0;
      if (int'(cur_row) + 1 == int'(sprite_cfg.sprite_height)) cur_row = '0;
      else cur_row = cur_row + 8'd1;
    end else begin
      cur_col = cur_col + 5'd1;
    end
  endfunction

  function automatic logic [7:0] pick_bits();
    case ($urandom_range(0, 5))
      0:       return 8'hFF;
      1:       return 8'h01 << $urandom_range(0, 7);
      2:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] bits, input logic restart);
    sprite_byte_t s;
    s.bits    = bits;
    s.restart = restart;
    bytes_to_send.push_back(s);
    queued_items++;
  endfunction

  // Hold one register write request until the block takes it
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register; spare upper data bits carry noise the block must mask
  task automatic write_regs(input int x, input int y, input int w, input int h,
                            input int color);
    write_reg(REG_SPRITE_X, 12'(x));
    write_reg(REG_SPRITE_Y, 12'(y));
    write_reg(REG_SPRITE_WIDTH, {3'($urandom), 9'(w)});
    write_reg(REG_SPRITE_HEIGHT, {3'($urandom), 9'(h)});
    write_reg(REG_FG_COLOR, {4'($urandom), 8'(color)});
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_FIRST_UNUSED + 3'($urandom_range(0, 2)), 12'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Wait until every request is taken and every write has come, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || push || pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present queued bytes, hold a request until taken, idle in bursts
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) void'(bytes_to_send.pop_front());
      if (!(push && full)) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (bytes_to_send.size() > 0) begin
          push        <= 1'b1;
          bitmap_byte <= bytes_to_send[0].bits;
          first_byte  <= bytes_to_send[0].restart;
          if (!calm && send_odds != 0 && $urandom_range(1, send_odds) == 1)
            send_gap = $urandom_range(1, 18);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: track register writes, predict accepted bytes, check popped writes
  always @(posedge clk) begin
    if (rst) begin
      sprite_cfg.sprite_x      = '0;
      sprite_cfg.sprite_y      = '0;
      sprite_cfg.sprite_width  = 9'd8;
      sprite_cfg.sprite_height = 9'd8;
      sprite_cfg.fg_color      = 8'd15;
      cur_col  = '0;
      cur_row  = '0;
      recv_gap = 0;
      pop <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPRITE_X:      sprite_cfg.sprite_x      = cfg_data;
          REG_SPRITE_Y:      sprite_cfg.sprite_y      = cfg_data;
          REG_SPRITE_WIDTH:  sprite_cfg.sprite_width  = cfg_data[8:0];
          REG_SPRITE_HEIGHT: sprite_cfg.sprite_height = cfg_data[8:0];
          REG_FG_COLOR:      sprite_cfg.fg_color      = cfg_data[7:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        bytes_accepted++;
        expand_byte(bitmap_byte, first_byte);
      end
      if (pop && !empty) begin
        writes_seen++;
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write at offset %0d", pixel_offset));
        end else begin
          want_write = pending_writes.pop_front();
          if (pixel_offset !== want_write.offset)
            report_mismatch($sformatf("pixel_offset %0d, expected %0d",
                                      pixel_offset, want_write.offset));
          if (pixel_color !== want_write.color)
            report_mismatch($sformatf("pixel_color %0d, expected %0d at offset %0d",
                                      pixel_color, want_write.color, want_write.offset));
          if (last_of_byte !== want_write.tail)
            report_mismatch($sformatf("last_of_byte %0b, expected %0b at offset %0d",
                                      last_of_byte, want_write.tail, want_write.offset));
        end
      end
      // Stall the result side in bursts
      if (calm) begin
        pop <= 1'b1;
      end else if (recv_gap > 0) begin
        pop <= 1'b0;
        recv_gap--;
      end else begin
        pop <= 1'b1;
        if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
          recv_gap = $urandom_range(1, 18);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes still expected",
               cycles, pending_writes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int x, y, w, h, color, eff_w, row_bytes, rows, n, style;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: 8x8 at the origin, mixed patterns, row wrap to the top
    send_odds = 4;
    recv_odds = 4;
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hC3, 1'b0);
    wait_idle();

    // Clip top and left, padding bits past a 13-pixel width
    write_regs(-3, -1, 13, 3, 0);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hE0, 1'b0);
    queue_byte(8'hFF, 1'b0);
    wait_idle();

    // Clip right and bottom edges
    write_regs(SCREEN_WIDTH - 4, SCREEN_HEIGHT - 1, 8, 2, 255);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    wait_idle();

    // Position registers at their extremes
    write_regs(-2048, 2047, 8, 8, 1);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // Narrow the width mid-row, then lower the height below the current row
    write_regs(0, 0, 64, 4, 90);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    wait_idle();
    write_regs(0, 0, 9, 4, 90);
    @(negedge clk);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    wait_idle();
    write_regs(0, 0, 9, 1, 90);
    @(negedge clk);
    queue_byte(8'hFF, 1'b0);
    wait_idle();

    // Zero width, then zero height
    write_regs(0, 0, 0, 8, 7);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    wait_idle();
    write_regs(0, 0, 8, 0, 7);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // Width past the maximum: one full row of 32 bytes
    write_regs(int'($urandom_range(0, 300)) - 200, $urandom_range(0, 198),
               $urandom_range(257, 511), 2, $urandom_range(0, 255));
    send_odds = 6;
    recv_odds = 3;
    @(negedge clk);
    for (int i = 0; i < 32; i++) queue_byte(pick_bits(), i == 0);
    wait_idle();

    // Walk the row counter to 254 with a zero width, then draw across the 8-bit wrap
    write_regs(0, 0, 0, 300, 0);
    send_odds = 0;
    @(negedge clk);
    for (int i = 0; i < 254; i++) queue_byte(8'($urandom), i == 0);
    wait_idle();
    write_regs($urandom_range(0, 300), 0, 8, 300, $urandom_range(0, 255));
    @(negedge clk);
    for (int i = 0; i < 6; i++) queue_byte(8'hFF, 1'b0);
    wait_idle();

    // Random sprites: mostly whole bitmaps, some continued walks and noise
    while (queued_items < 340) begin
      case ($urandom_range(0, 11))
        0:       x = -2048;
        1:       x = 2047;
        2:       x = $urandom_range(0, 4095);
        3:       x = SCREEN_WIDTH - int'($urandom_range(1, 8));
        default: x = int'($urandom_range(0, 330)) - 12;
      endcase
      case ($urandom_range(0, 11))
        0:       y = -2048;
        1:       y = 2047;
        2:       y = SCREEN_HEIGHT - int'($urandom_range(1, 4));
        default: y = int'($urandom_range(0, 204)) - 6;
      endcase
      case ($urandom_range(0, 11))
        0:       w = 0;
        1:       w = 1;
        2:       w = 8;
        3:       w = $urandom_range(257, 511);
        4:       w = 256;
        default: w = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 11))
        0:       h = 0;
        1:       h = 1;
        2:       h = $urandom_range(257, 511);
        default: h = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 5))
        0:       color = 0;
        1:       color = 255;
        default: color = $urandom_range(0, 255);
      endcase
      eff_w     = (w > MAX_SPRITE_SIZE) ? MAX_SPRITE_SIZE : w;
      row_bytes = (eff_w + 7) / 8;
      rows      = (h == 0 || h > MAX_SPRITE_SIZE) ? 3 : h;
      n         = (row_bytes == 0) ? $urandom_range(2, 6)
                                   : rows * row_bytes + $urandom_range(0, row_bytes);
      if (n > 40) n = 40;
      style = $urandom_range(0, 9);

      write_regs(x, y, w, h, color);
      if (queued_items >= 325) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       send_odds = 0;
        1:       send_odds = 3;
        default: send_odds = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_odds = 0;
        1:       recv_odds = 3;
        default: recv_odds = 12;
      endcase
      @(negedge clk);
      for (int i = 0; i < n; i++) begin
        if (style == 9) queue_byte(pick_bits(), 1'($urandom));
        else queue_byte(pick_bits(), style < 8 && i == 0);
      end
      wait_idle();
    end

    $display("Sent %0d bitmap bytes under %0d register settings, checked %0d pixel writes.",
             bytes_accepted, settings, writes_seen);
    $display("Covered clipping on all edges, padding, oversize and zero geometry, row wrap.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
